>>> design/apcs_pkg.sv
// ----------------------------------------------------------------------------
// apcs_pkg: shared types and constants of the adaptive polar curve sampler
// Fixed-point constants, the CORDIC arctangent table and the structs that
// link the register file, the divider, the CORDIC engine and the top level.
// ----------------------------------------------------------------------------
package apcs_pkg;

    // Default values of the top-level parameters.
    localparam int CORDIC_ITERATIONS_DEF = 24;
    localparam int RADIUS_FRAC_BITS_DEF  = 16;

    // Angle step limits, units of 2^-24 rad.
    localparam int              STEP_W         = 22;
    localparam logic [STEP_W-1:0] STEP_MIN     = 22'd29282;    // pi/1800
    localparam logic [STEP_W-1:0] STEP_MAX     = 22'd2928177;  // pi/18
    localparam logic [STEP_W-1:0] BASE_STEP_RST = 22'd1672166;

    // Data widths.
    localparam int DATA_W = 32;   // radius, coordinates, angles
    localparam int Z_W    = 58;   // angle accumulator, units of 2^-48 rad
    localparam int XY_W   = 52;   // CORDIC vector, units of 2^-32
    localparam int K_W    = 7;    // quarter-turn count, |k| stays below 128
    localparam int KCNT_W = $clog2(K_W);

    // Constants for the rotation.
    localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
    localparam logic [63:0] HALF_PI48 = (PI_Q60 + 64'd4096) >> 13;
    localparam logic [63:0] HALF_PI48_HALF = HALF_PI48 >> 1;
    localparam logic [31:0] CORDIC_GAIN = 32'h9B74EDA8;

    // Arctangent table, round(atan(2^-i) * 2^48).
    localparam int MAX_ITER   = 32;
    localparam int ATAN_IDX_W = $clog2(MAX_ITER);

    typedef logic [Z_W-1:0] t_atan_tab [MAX_ITER];

    // Unsigned long division by shift and subtract, used only while the
    // arctangent table is built.
    function automatic longint f_udiv64(input longint num, input longint den);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int pos = 62; pos >= 0; pos--) begin
            rem = (rem <<< 1) | ((num >>> pos) & 64'sd1);
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (64'sd1 <<< pos);
            end
        end
        return quo;
    endfunction

    function automatic t_atan_tab f_build_atan();
        t_atan_tab tab;
        longint    acc;
        longint    term;
        int        e;
        tab[0] = Z_W'((PI_Q60 + 64'd8192) >> 14);
        for (int i = 1; i < MAX_ITER; i++) begin
            acc = 0;
            for (int k = 0; k < MAX_ITER; k++) begin
                e = i * (2 * k + 1);
                if (e <= 62) begin
                    term = f_udiv64(longint'(64'd1 << (62 - e)), longint'(2 * k + 1));
                    if (k[0]) begin
                        acc = acc - term;
                    end else begin
                        acc = acc + term;
                    end
                end
            end
            tab[i] = Z_W'((acc + 64'sd8192) >>> 14);
        end
        return tab;
    endfunction

    localparam t_atan_tab ATAN_TAB = f_build_atan();

    // Register map, byte address 4 * index.
    localparam int PADDR_W = 4;
    typedef enum logic [1:0] {
        REG_ANGLE_A   = 2'd0,
        REG_ANGLE_B   = 2'd1,
        REG_BASE_STEP = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] angle_a;
        logic signed [DATA_W-1:0] angle_b;
        logic [STEP_W-1:0]        base_step;
    } t_cfg;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] angle;
        logic [DATA_W-1:0]        mag;
        logic                     neg;
    } t_cor_req;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } t_cor_rsp;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] base;
        logic [DATA_W-1:0] mag;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [STEP_W-1:0] step;
    } t_div_rsp;

    typedef enum logic [2:0] {
        COR_IDLE,
        COR_REDUCE,
        COR_PREP,
        COR_ROT,
        COR_QUAD,
        COR_ROUND
    } t_cor_state;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_LAUNCH,
        TOP_CALC
    } t_top_state;

endpackage

>>> design/adaptive_polar_curve_sampler_top.sv
// An accepted request passes TOP_LAUNCH, then waits in TOP_CALC for both
// engines and a free output register before m_axis_tvalid rises.
// A new request is taken only after the previous one has been loaded into the
// output register; each request runs the restoring step divider (one quotient
// bit per cycle) and the CORDIC loop (one rotation per cycle).
// Reset (synchronous, active low) clears the sweep so the next request starts it.
// ----------------------------------------------------------------------------
// adaptive_polar_curve_sampler_top: adaptive polar curve sampler
// Converts one radius per request into a Cartesian point at the current sweep
// angle and advances the angle by a step that shrinks as the radius grows.
// ----------------------------------------------------------------------------
module adaptive_polar_curve_sampler_top
    import apcs_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
    parameter int RADIUS_FRAC_BITS  = RADIUS_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input request stream.
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,   // [31:0] radius
    input  logic [0:0]         s_axis_tuser,   // [0] radius_valid
    // Output point stream.
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [95:0]        m_axis_tdata,   // [31:0] x_pos, [63:32] y_pos,
                                               // [95:64] point_angle
    output logic               m_axis_tlast,   // last_point
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Control state.
    t_top_state r_state, n_state;
    logic       r_sweep_start;
    logic       r_past_range;
    logic       r_cdone;
    logic       r_ddone;
    logic       r_out_valid;

    // Sweep position and the request in flight.
    logic signed [DATA_W-1:0] r_cur_angle;
    logic signed [DATA_W-1:0] r_radius;
    logic                     r_rvalid;
    logic signed [DATA_W-1:0] r_ang;
    logic                     r_last;

    // Output register.
    logic signed [DATA_W-1:0] r_x_pos;
    logic signed [DATA_W-1:0] r_y_pos;
    logic signed [DATA_W-1:0] r_point_angle;
    logic                     r_last_point;

    t_cfg     cfg;
    t_cor_req cor_req;
    t_cor_rsp cor_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic                     in_acc;
    logic                     launch;
    logic                     load_out;
    logic                     all_done;
    logic                     out_free;
    logic signed [DATA_W-1:0] bound_lo;
    logic signed [DATA_W-1:0] bound_hi;
    logic signed [DATA_W-1:0] ang_sel;
    logic                     last_sel;
    logic [STEP_W-1:0]        base_clamped;
    logic [DATA_W-1:0]        rad_mag;
    logic [STEP_W-1:0]        step;
    logic signed [DATA_W:0]   next_angle;
    logic                     angle_ovf;

    apcs_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    assign pready = 1'b1;

    // The bounds are read live on every request; the smaller one is the
    // start of the sweep and the larger one its end.
    assign bound_lo = (cfg.angle_a <= cfg.angle_b) ? cfg.angle_a : cfg.angle_b;
    assign bound_hi = (cfg.angle_a <= cfg.angle_b) ? cfg.angle_b : cfg.angle_a;

    // A fresh sweep takes the start bound. Otherwise an angle beyond the end,
    // or one whose last advance overflowed, is pinned to the end and closes
    // the sweep. An angle exactly at the end is not the last point.
    always_comb begin
        ang_sel  = r_cur_angle;
        last_sel = 1'b0;
        if (r_sweep_start) begin
            ang_sel = bound_lo;
        end else if (r_past_range || (r_cur_angle > bound_hi)) begin
            ang_sel  = bound_hi;
            last_sel = 1'b1;
        end
    end

    assign base_clamped = (cfg.base_step < STEP_MIN) ? STEP_MIN :
                          (cfg.base_step > STEP_MAX) ? STEP_MAX : cfg.base_step;

    // Magnitude of the radius; the most negative code maps to 2^31.
    assign rad_mag = r_radius[DATA_W-1] ? (~r_radius + 32'd1) : r_radius;

    // Both engines start together from TOP_LAUNCH, in the cycle after the request is taken.
    assign cor_req.start = launch;
    assign cor_req.angle = r_ang;
    assign cor_req.mag   = rad_mag;
    assign cor_req.neg   = r_radius[DATA_W-1];

    assign div_req.start = launch;
    assign div_req.base  = base_clamped;
    assign div_req.mag   = rad_mag;

    apcs_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_rsp   (cor_rsp)
    );

    apcs_divider #(
        .FRAC_BITS (RADIUS_FRAC_BITS)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Step selection: an undefined radius keeps the clamped base step, a zero radius
    // takes the largest step, anything else uses the clamped quotient.
    always_comb begin
        if (!r_rvalid) begin
            step = base_clamped;
        end else if (r_radius == '0) begin
            step = STEP_MAX;
        end else begin
            step = div_rsp.step;
        end
    end

    assign next_angle = {r_ang[DATA_W-1], r_ang} + $signed({{(DATA_W+1-STEP_W){1'b0}}, step});
    // The step is positive, so only a carry past the top can happen.
    assign angle_ovf  = (next_angle[DATA_W:DATA_W-1] == 2'b01);

    assign all_done = (r_cdone | cor_rsp.done) & (r_ddone | div_rsp.done);
    assign out_free = ~r_out_valid | m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TOP_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        launch        = 1'b0;
        load_out      = 1'b0;
        case (r_state)
            TOP_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = TOP_LAUNCH;
                end
            end
            TOP_LAUNCH: begin
                launch  = 1'b1;
                n_state = TOP_CALC;
            end
            TOP_CALC: begin
                if (all_done && out_free) begin
                    load_out = 1'b1;
                    n_state  = TOP_IDLE;
                end
            end
            default: n_state = TOP_IDLE;
        endcase
    end

    assign in_acc = s_axis_tvalid & s_axis_tready;

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_radius <= s_axis_tdata;
            r_rvalid <= s_axis_tuser[0];
            r_ang    <= ang_sel;
            r_last   <= last_sel;
        end
    end

    // Engine completion flags; the two engines may finish at different times.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cdone <= 1'b0;
            r_ddone <= 1'b0;
        end else if (launch || load_out) begin
            r_cdone <= 1'b0;
            r_ddone <= 1'b0;
        end else begin
            r_cdone <= r_cdone | cor_rsp.done;
            r_ddone <= r_ddone | div_rsp.done;
        end
    end

    // Sweep state advances when the point leaves for the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_angle   <= '0;
            r_sweep_start <= 1'b1;
            r_past_range  <= 1'b0;
        end else if (load_out) begin
            if (r_last) begin
                r_sweep_start <= 1'b1;
                r_past_range  <= 1'b0;
            end else begin
                r_sweep_start <= 1'b0;
                r_past_range  <= angle_ovf;
                r_cur_angle   <= angle_ovf ? 32'sh7FFF_FFFF : next_angle[DATA_W-1:0];
            end
        end
    end

    // Output register: a new request can be taken while a point waits here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_x_pos       <= r_rvalid ? cor_rsp.x : '0;
            r_y_pos       <= r_rvalid ? cor_rsp.y : '0;
            r_point_angle <= r_ang;
            r_last_point  <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_point_angle, r_y_pos, r_x_pos};
    assign m_axis_tlast  = r_last_point;

`ifndef SYNTHESIS
    // An overflowed advance always parks the angle at the top code.
    a_past_range_pinned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_past_range |-> (r_cur_angle == 32'sh7FFF_FFFF))
        else $error("past-range flag set without a pinned angle");

    // A closing point restarts the sweep on the next request.
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_last) |=> (r_sweep_start && !r_past_range))
        else $error("last point did not restart the sweep");

    // No stale engine completion survives into the idle state.
    a_idle_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == TOP_IDLE) |-> (!r_cdone && !r_ddone))
        else $error("engine completion flag left over in idle");

    // The divider step is always inside the legal range.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> ((div_rsp.step >= STEP_MIN) && (div_rsp.step <= STEP_MAX)))
        else $error("divider step out of range");
`endif

endmodule

>>> design/apcs_apb_regs.sv
// ----------------------------------------------------------------------------
// apcs_apb_regs: configuration registers
// Holds the two sweep bounds and the base step behind an APB-style port.
// ----------------------------------------------------------------------------
module apcs_apb_regs
    import apcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_a   <= '0;
            r_cfg.angle_b   <= '0;
            r_cfg.base_step <= BASE_STEP_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ANGLE_A:   r_cfg.angle_a   <= pwdata;
                REG_ANGLE_B:   r_cfg.angle_b   <= pwdata;
                REG_BASE_STEP: r_cfg.base_step <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ANGLE_A:   prdata = r_cfg.angle_a;
            REG_ANGLE_B:   prdata = r_cfg.angle_b;
            REG_BASE_STEP: prdata = 32'(r_cfg.base_step);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/apcs_divider.sv
// ----------------------------------------------------------------------------
// apcs_divider: restoring divider for the adaptive angle step
// Computes floor(base * 2^F / mag), one quotient bit per cycle, and clamps
// the quotient to the legal step range.
// ----------------------------------------------------------------------------
module apcs_divider
    import apcs_pkg::*;
#(
    parameter int FRAC_BITS = RADIUS_FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int NUM_W = STEP_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [NUM_W-1:0]    r_num;     // numerator bits out, quotient bits in
    logic [DATA_W-1:0]   r_rem;
    logic [DATA_W-1:0]   r_mag;

    logic [DATA_W:0]     rem_sh;
    logic [DATA_W+1:0]   diff;
    logic                q_bit;

    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_mag};
    assign q_bit  = ~diff[DATA_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= {i_req.base, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_mag <= i_req.mag;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], q_bit};
            r_rem <= q_bit ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        if (r_num > NUM_W'(STEP_MAX)) begin
            o_rsp.step = STEP_MAX;
        end else if (r_num < NUM_W'(STEP_MIN)) begin
            o_rsp.step = STEP_MIN;
        end else begin
            o_rsp.step = r_num[STEP_W-1:0];
        end
    end

endmodule

>>> design/apcs_cordic.sv
// ----------------------------------------------------------------------------
// apcs_cordic: iterative polar-to-Cartesian engine
// Reduces the angle by quarter turns with a shift-subtract loop, rotates the
// gain-scaled radius one CORDIC step per cycle, restores the quadrant and
// sign, then rounds and saturates both coordinates.
// ----------------------------------------------------------------------------
module apcs_cordic
    import apcs_pkg::*;
#(
    parameter int ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cor_req i_req,
    output t_cor_rsp o_rsp
);

    localparam int ITER_W = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;
    localparam logic signed [XY_W-1:0] SAT_HI = XY_W'(33'sd2147483647);
    localparam logic signed [XY_W-1:0] SAT_LO = XY_W'(-33'sd2147483648);
    localparam logic signed [XY_W-1:0] RND_HALF = XY_W'(33'sd32768);

    t_cor_state r_state, n_state;

    logic [KCNT_W-1:0]        r_kcnt;
    logic [ITER_W-1:0]        r_iter;
    logic signed [Z_W-1:0]    r_z;
    logic [Z_W-1:0]           r_dvs;
    logic [K_W-1:0]           r_k;
    logic signed [XY_W-1:0]   r_x;
    logic signed [XY_W-1:0]   r_y;
    logic [DATA_W-1:0]        r_mag;
    logic                     r_rneg;
    logic                     r_aneg;
    logic signed [DATA_W-1:0] r_xo;
    logic signed [DATA_W-1:0] r_yo;
    logic                     r_done;

    logic [DATA_W-1:0]        ang_mag;
    logic signed [Z_W-1:0]    h2s;
    logic signed [Z_W-1:0]    red_diff;
    logic [2*DATA_W-1:0]      prod;
    logic signed [XY_W-1:0]   dx;
    logic signed [XY_W-1:0]   dy;
    logic signed [Z_W-1:0]    atan_s;
    logic [1:0]               quad;
    logic signed [XY_W-1:0]   qx, qy;
    logic signed [XY_W-1:0]   rx, ry;

    function automatic logic signed [DATA_W-1:0] f_sat(input logic signed [XY_W-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[DATA_W-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= COR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            COR_IDLE:   if (i_req.start) n_state = COR_REDUCE;
            COR_REDUCE: if (r_kcnt == KCNT_W'(K_W - 1)) n_state = COR_PREP;
            COR_PREP:   n_state = COR_ROT;
            COR_ROT:    if (r_iter == ITER_W'(ITERATIONS - 1)) n_state = COR_QUAD;
            COR_QUAD:   n_state = COR_ROUND;
            COR_ROUND:  n_state = COR_IDLE;
            default:    n_state = COR_IDLE;
        endcase
    end

    // Datapath terms.
    assign ang_mag  = i_req.angle[DATA_W-1] ? (~i_req.angle + 32'd1) : i_req.angle;
    assign h2s      = $signed(Z_W'(HALF_PI48_HALF));
    assign red_diff = r_z - $signed(r_dvs);
    assign prod     = r_mag * CORDIC_GAIN;
    assign dx       = r_y >>> r_iter;
    assign dy       = r_x >>> r_iter;
    assign atan_s   = $signed(ATAN_TAB[ATAN_IDX_W'(r_iter)]);
    // The reduction count is |k|; a negative angle needs -k modulo four.
    assign quad     = r_aneg ? 2'(~r_k[1:0] + 2'd1) : r_k[1:0];
    assign rx       = (r_x + RND_HALF) >>> 16;
    assign ry       = (r_y + RND_HALF) >>> 16;

    always_comb begin
        case (quad)
            QUAD_90: begin
                qx = -r_y;
                qy = r_x;
            end
            QUAD_180: begin
                qx = -r_x;
                qy = -r_y;
            end
            QUAD_270: begin
                qx = r_y;
                qy = -r_x;
            end
            default: begin
                qx = r_x;
                qy = r_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            COR_IDLE: begin
                if (i_req.start) begin
                    r_z    <= $signed(Z_W'({ang_mag, 24'd0}) + Z_W'(HALF_PI48_HALF));
                    r_dvs  <= Z_W'(HALF_PI48 << (K_W - 1));
                    r_k    <= '0;
                    r_kcnt <= '0;
                    r_mag  <= i_req.mag;
                    r_rneg <= i_req.neg;
                    r_aneg <= i_req.angle[DATA_W-1];
                end
            end
            COR_REDUCE: begin
                if (!red_diff[Z_W-1]) begin
                    r_z <= red_diff;
                end
                r_k    <= {r_k[K_W-2:0], ~red_diff[Z_W-1]};
                r_dvs  <= r_dvs >> 1;
                r_kcnt <= r_kcnt + 1'b1;
                r_x    <= $signed(XY_W'(prod[2*DATA_W-1:16]));
                r_y    <= '0;
            end
            COR_PREP: begin
                r_z    <= r_aneg ? (h2s - r_z) : (r_z - h2s);
                r_iter <= '0;
            end
            COR_ROT: begin
                if (!r_z[Z_W-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_s;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_s;
                end
                r_iter <= r_iter + 1'b1;
            end
            COR_QUAD: begin
                r_x <= r_rneg ? -qx : qx;
                r_y <= r_rneg ? -qy : qy;
            end
            COR_ROUND: begin
                r_xo <= f_sat(rx);
                r_yo <= f_sat(ry);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == COR_ROUND);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.x    = r_xo;
    assign o_rsp.y    = r_yo;

endmodule
